@@ src/b64e_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg - shared types and constants for the Base64 stream encoder
// Holds the queue entry layout and the sextet-to-ASCII alphabet mapping.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned SYM_W   = 6;  // one Base64 sextet
    localparam int unsigned MAX_SYM = 4;  // characters one byte can produce
    localparam int unsigned IDX_W   = 2;  // index into the symbols of an entry

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    // Work for one input byte: up to four sextets, pad markers, last used slot.
    typedef struct packed {
        logic [MAX_SYM-1:0][SYM_W-1:0] sym;
        logic [MAX_SYM-1:0]            pad;
        logic [IDX_W-1:0]              last_idx;
    } b64e_entry_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] b64_char(input logic [SYM_W-1:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = 8'h41 + w;
        end else if (v < 6'd52) begin
            c = 8'h61 + w - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + w - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ src/base64_stream_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder - streaming Base64 encoder, standard alphabet
// Encodes a byte stream to Base64 characters with '=' padding at the end of
// each message.
// ----------------------------------------------------------------------------
// Each input transaction carries one message byte, with s_tlast marking the
// final byte. Each output transaction carries one ASCII character; m_tlast is
// set on the last character produced for a given input byte. A byte yields
// one character (first or second byte of a group), two (third byte), three
// (second byte flagged last: char, char, '=') or four (first byte flagged
// last: char, char, '=', '='). After a flagged byte the next byte starts a
// fresh group. The output serializer issues one character per clock while it
// has an entry and m_tready does not hold it, and so sets the sustained rate.
// The input side accepts a byte every cycle while the FIFO_DEPTH-entry queue
// between the classifier and the serializer has room. While a character waits
// on m_tready in the output register the serializer holds, and the queue keeps
// taking bytes until full. A byte passes through the queue, the serializer's
// entry register and the output register before its first character appears.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int unsigned FIFO_DEPTH = 2
) (
    input  wire        aclk,
    input  wire        aresetn,
    // input byte stream
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] data_byte
    input  wire        s_tlast,   // last_byte
    // output character stream
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // out_last
);
    import b64e_pkg::*;

    b64e_entry_t push_entry;
    b64e_entry_t head_entry;
    logic        push, can_push, head_valid, pop;

    // Front: phase tracking and sextet extraction for each byte.
    b64e_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_ready  (can_push),
        .in_ready (s_tready),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    // Queue decouples byte intake from character output.
    b64e_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .can_push   (can_push),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back: alphabet lookup and one character per transaction.
    b64e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .out_ready  (m_tready),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
`default_nettype wire

@@ src/b64e_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front - input byte classifier
// Tracks group phase and leftover bits, turns each accepted byte into a
// queue entry holding its sextets and padding.
// ----------------------------------------------------------------------------
module b64e_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    input  wire  [7:0]            in_byte,
    input  wire                   in_last,
    input  wire                   q_ready,
    output logic                  in_ready,
    output logic                  q_push,
    output b64e_pkg::b64e_entry_t q_entry
);
    import b64e_pkg::*;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;  // low two bits used after a first byte, all four after a second

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    always_comb begin
        q_entry    = '0;
        phase_next = PH_FIRST;
        carry_next = '0;
        case (phase_reg)
            PH_SECOND: begin
                q_entry.sym[0] = {carry_reg[1:0], in_byte[7:4]};
                if (in_last) begin
                    q_entry.sym[1]   = {in_byte[3:0], 2'b00};
                    q_entry.pad[2]   = 1'b1;
                    q_entry.last_idx = 2'd2;
                end else begin
                    q_entry.last_idx = 2'd0;
                    phase_next       = PH_THIRD;
                    carry_next       = in_byte[3:0];
                end
            end
            PH_THIRD: begin
                q_entry.sym[0]   = {carry_reg[3:0], in_byte[7:6]};
                q_entry.sym[1]   = in_byte[5:0];
                q_entry.last_idx = 2'd1;
            end
            default: begin  // first byte of a group (phase 3 cannot occur)
                q_entry.sym[0] = in_byte[7:2];
                if (in_last) begin
                    q_entry.sym[1]   = {in_byte[1:0], 4'b0000};
                    q_entry.pad[2]   = 1'b1;
                    q_entry.pad[3]   = 1'b1;
                    q_entry.last_idx = 2'd3;
                end else begin
                    q_entry.last_idx = 2'd0;
                    phase_next       = PH_SECOND;
                    carry_next       = in_byte[3:0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            carry_reg <= '0;
        end else if (q_push) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("front: group phase left its range");

    a_close_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && (in_last || phase_reg == PH_THIRD)) |=> phase_reg == PH_FIRST)
        else $error("front: group not closed after last or third byte");

    a_third_two_chars: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && phase_reg == PH_THIRD) |-> (q_entry.last_idx == 2'd1 && q_entry.pad == '0))
        else $error("front: third byte must yield exactly two characters");

endmodule
`default_nettype wire

@@ src/b64e_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue - short entry queue between front and back
// Register-based FIFO; read data is the head entry, shown while not empty.
// ----------------------------------------------------------------------------
module b64e_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  b64e_pkg::b64e_entry_t push_entry,
    input  wire                   pop,
    output logic                  can_push,
    output logic                  head_valid,
    output b64e_pkg::b64e_entry_t head_entry
);
    import b64e_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64e_entry_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign can_push   = count_reg != FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && can_push;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue: occupancy above depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !can_push))
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !head_valid))
        else $error("queue: pop while empty");

endmodule
`default_nettype wire

@@ src/b64e_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back - character serializer
// Takes queue entries and emits one ASCII character per cycle into an output
// register unless stalled; the next entry loads as the last character leaves.
// ----------------------------------------------------------------------------
module b64e_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   head_valid,
    input  b64e_pkg::b64e_entry_t head_entry,
    input  wire                   out_ready,
    output logic                  pop,
    output logic                  out_valid,
    output logic [7:0]            out_char,
    output logic                  out_last
);
    import b64e_pkg::*;

    b64e_entry_t      entry_reg, entry_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic             out_load, emit, fin;
    logic [7:0]       cur_char;

    assign out_load = !valid_reg || out_ready;
    assign emit     = busy_reg && out_load;
    assign fin      = emit && (idx_reg == entry_reg.last_idx);
    assign pop      = head_valid && (!busy_reg || fin);
    assign cur_char = entry_reg.pad[idx_reg] ? PAD_CHAR : b64_char(entry_reg.sym[idx_reg]);

    always_comb begin
        entry_next = pop ? head_entry : entry_reg;
        busy_next  = pop ? 1'b1 : (fin ? 1'b0 : busy_reg);
        idx_next   = pop ? '0 : (emit ? idx_reg + 1'b1 : idx_reg);
        valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        char_next  = emit ? cur_char : char_reg;
        last_next  = emit ? (idx_reg == entry_reg.last_idx) : last_reg;
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    a_idx_in_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg <= entry_reg.last_idx)
        else $error("back: symbol index past end of entry");

    a_pop_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!busy_reg || fin))
        else $error("back: entry loaded while previous still in flight");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench for base64_stream_encoder
// Drives whole messages of raw bytes into the encoder, predicts the Base64
// character stream in a scoreboard and checks every output transaction under
// several source idle and sink stall patterns, including a long sink hold-off.
// ----------------------------------------------------------------------------

class char_scoreboard;
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } b64_char_t;

    string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    b64_char_t   pending_chars[$];
    logic [1:0]  grp_phase;
    logic [7:0]  prev_byte;
    int          mismatches;
    int          bytes_seen;
    int          msgs_seen;
    int          chars_checked;

    function new();
        grp_phase     = 2'd0;
        prev_byte     = 8'h00;
        mismatches    = 0;
        bytes_seen    = 0;
        msgs_seen     = 0;
        chars_checked = 0;
    endfunction

    function void push_sextet(logic [5:0] v, logic l);
        b64_char_t e;
        e.ch   = alphabet[v];
        e.last = l;
        pending_chars.push_back(e);
    endfunction

    function void push_pad(logic l);
        b64_char_t e;
        e.ch   = b64e_pkg::PAD_CHAR;
        e.last = l;
        pending_chars.push_back(e);
    endfunction

    // Encoder prediction for one accepted byte.
    function void note_byte(logic [7:0] b, logic l);
        bytes_seen++;
        if (l) msgs_seen++;
        case (grp_phase)
            2'd1: begin
                if (!l) begin
                    push_sextet({prev_byte[1:0], b[7:4]}, 1'b1);
                    prev_byte = b;
                    grp_phase = 2'd2;
                end else begin
                    push_sextet({prev_byte[1:0], b[7:4]}, 1'b0);
                    push_sextet({b[3:0], 2'b00}, 1'b0);
                    push_pad(1'b1);
                    prev_byte = 8'h00;
                    grp_phase = 2'd0;
                end
            end
            2'd2: begin
                // third byte completes the group; last flag adds no padding
                push_sextet({prev_byte[3:0], b[7:6]}, 1'b0);
                push_sextet(b[5:0], 1'b1);
                prev_byte = 8'h00;
                grp_phase = 2'd0;
            end
            default: begin
                if (!l) begin
                    push_sextet(b[7:2], 1'b1);
                    prev_byte = b;
                    grp_phase = 2'd1;
                end else begin
                    push_sextet(b[7:2], 1'b0);
                    push_sextet({b[1:0], 4'b0000}, 1'b0);
                    push_pad(1'b0);
                    push_pad(1'b1);
                    prev_byte = 8'h00;
                    grp_phase = 2'd0;
                end
            end
        endcase
    endfunction

    function void check_char(logic [7:0] c, logic l);
        b64_char_t e;
        if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected char %02h last %0b", c, l);
            return;
        end
        e = pending_chars.pop_front();
        chars_checked++;
        if (c !== e.ch || l !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: char #%0d expected %02h last %0b, got %02h last %0b",
                         chars_checked, e.ch, e.last, c, l);
        end
    endfunction

    function int pending();
        return pending_chars.size();
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 200000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_cycles   = 0;
    int cycle_cnt     = 0;

    char_scoreboard sb = new();

    base64_stream_encoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // monitor: values read here are the ones the edge samples
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_char(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chars outstanding", cycle_cnt,
                     sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // sink: random stalls, plus a counted hold-off when requested
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // random messages until about n_bytes have gone in
    task automatic run_phase(input int idle, input int stall, input int n_bytes);
        int sent;
        int len;
        src_idle_pct   = idle;
        sink_stall_pct = stall;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 15) : $urandom_range(10, 1);
            for (int i = 0; i < len; i++) send_byte(rand_byte(), i == len - 1);
            sent += len;
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one- and two-byte messages (double and single pad),
        // last flag on a third byte, every alphabet range, '+' and '/'
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'hD3, 1'b0);
        send_byte(8'h5D, 1'b0);
        send_byte(8'hB7, 1'b1);
        send_byte(8'hAA, 1'b1);

        run_phase(0, 0, 90);
        run_phase(55, 0, 90);
        run_phase(0, 55, 90);
        run_phase(9, 9, 90);

        // long sink hold-off while the source keeps pushing: input must stall
        s_tvalid <= 1'b0;
        wait_drained();
        hold_cycles = 300;
        run_phase(0, 0, 90);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("covered %0d bytes in %0d messages, %0d characters checked",
                 sb.bytes_seen, sb.msgs_seen, sb.chars_checked);
        $display("phases: free-running, source idle, sink stall, both, long sink hold-off;"
                 , " %0d mismatches", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
sim/tb.sv
